// ===== src/fbfl_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and codes for the fixed-size block pool free list.
package fbfl_pkg;

   // Fixed field widths of the request and response channels.
   localparam int CMD_W     = 1;
   localparam int IDX_IN_W  = 8;
   localparam int BLK_OUT_W = 8;
   localparam int CNT_OUT_W = 9;

   // Request command codes.
   localparam logic [CMD_W-1:0] CMD_ALLOC = 1'b0;
   localparam logic [CMD_W-1:0] CMD_FREE  = 1'b1;

   // Controller states.
   typedef enum logic [1:0] {
      ST_INIT,
      ST_IDLE,
      ST_EXEC
   } fbfl_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic sweep_en;
      logic capture;
      logic execute;
   } fbfl_ctrl_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic sweep_last;
      logic rsp_room;
   } fbfl_stat_type;

endpackage

// ===== src/fbfl_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine for the block pool free list.
module fbfl_ctrl
   import fbfl_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  fbfl_stat_type stat,
   output fbfl_ctrl_type ctrl
);

   fbfl_state_type state_ff;
   fbfl_state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and command decode.
   always_comb begin
      state_in      = state_ff;
      ctrl.sweep_en = 1'b0;
      ctrl.capture  = 1'b0;
      ctrl.execute  = 1'b0;
      req_ready     = 1'b0;
      case (state_ff)
         ST_INIT: begin
            // Load the ascending link chain, one entry per cycle.
            ctrl.sweep_en = 1'b1;
            if (stat.sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctrl.capture = 1'b1;
               state_in     = ST_EXEC;
            end
         end
         ST_EXEC: begin
            // Wait here only while the response register holds a result that is not being taken.
            if (stat.rsp_room) begin
               ctrl.execute = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

endmodule

// ===== src/fbfl_dpath.sv =====
`timescale 1ns / 1ps
// Datapath for the block pool free list: link memory, head, count and response register.
module fbfl_dpath
   import fbfl_pkg::*;
#(
   parameter int NUM_BLOCKS = 256
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  fbfl_ctrl_type        ctrl,
   output fbfl_stat_type        stat,
   input  logic [CMD_W-1:0]     req_command,
   input  logic [IDX_IN_W-1:0]  req_free_index,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_ok,
   output logic [BLK_OUT_W-1:0] rsp_block_index,
   output logic [CNT_OUT_W-1:0] rsp_free_count
);

   localparam int IDX_W  = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
   localparam int LINK_W = $clog2(NUM_BLOCKS + 1);
   localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(NUM_BLOCKS);
   localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(NUM_BLOCKS - 1);

   // Link memory: each entry holds the next free block or null.
   logic [LINK_W-1:0] link_mem [NUM_BLOCKS];

   logic [LINK_W-1:0]    head_ff,  head_in;
   logic [LINK_W-1:0]    total_ff, total_in;
   logic [IDX_W-1:0]     sweep_ff;
   logic [LINK_W-1:0]    rd_data_ff;
   logic [CMD_W-1:0]     cmd_ff;
   logic [IDX_IN_W-1:0]  idx_ff;
   logic                 rsp_valid_ff;
   logic                 rsp_ok_ff,    rsp_ok_in;
   logic [BLK_OUT_W-1:0] rsp_block_ff, rsp_block_in;
   logic [CNT_OUT_W-1:0] rsp_count_ff;
   logic                 wr_en;
   logic [IDX_W-1:0]     wr_addr;
   logic [LINK_W-1:0]    wr_data;
   logic                 in_pool;

   // Link memory write port and registered read of the current head entry.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         link_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= link_mem[head_ff[IDX_W-1:0]];
   end

   // Operation decode: pop on allocate, push on free.
   always_comb begin
      in_pool      = (32'(idx_ff) < NUM_BLOCKS);
      head_in      = head_ff;
      total_in     = total_ff;
      rsp_ok_in    = 1'b0;
      rsp_block_in = '0;
      wr_en        = 1'b0;
      wr_addr      = sweep_ff;
      wr_data      = LINK_W'(sweep_ff) + LINK_W'(1);
      if (ctrl.sweep_en) begin
         wr_en = 1'b1;
      end else if (cmd_ff == CMD_ALLOC) begin
         if (head_ff != LINK_NULL) begin
            rsp_ok_in    = 1'b1;
            rsp_block_in = BLK_OUT_W'(head_ff);
            head_in      = rd_data_ff;
            if (total_ff != '0) begin
               total_in = total_ff - LINK_W'(1);
            end
         end
      end else begin
         if ((total_ff != LINK_NULL) && in_pool) begin
            rsp_ok_in = 1'b1;
            head_in   = LINK_W'(idx_ff);
            total_in  = total_ff + LINK_W'(1);
            wr_en     = ctrl.execute;
            wr_addr   = IDX_W'(idx_ff);
            wr_data   = head_ff;
         end
      end
   end

   // Head pointer, free count and sweep counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         total_ff <= LINK_W'(NUM_BLOCKS);
         sweep_ff <= '0;
      end else begin
         if (ctrl.sweep_en) begin
            sweep_ff <= sweep_ff + IDX_W'(1);
         end
         if (ctrl.execute) begin
            head_ff  <= head_in;
            total_ff <= total_in;
         end
      end
   end

   // Capture the request payload on transfer.
   always_ff @(posedge clock) begin
      if (ctrl.capture) begin
         cmd_ff <= req_command;
         idx_ff <= req_free_index;
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.execute) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.execute) begin
         rsp_ok_ff    <= rsp_ok_in;
         rsp_block_ff <= rsp_block_in;
         rsp_count_ff <= CNT_OUT_W'(total_in);
      end
   end

   assign stat.sweep_last = (sweep_ff == LAST_IDX);
   assign stat.rsp_room   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_ok          = rsp_ok_ff;
   assign rsp_block_index = rsp_block_ff;
   assign rsp_free_count  = rsp_count_ff;

   // The free count never exceeds the pool size.
   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      total_ff <= LINK_W'(NUM_BLOCKS))
      else $error("free count above pool size");

   // An executed operation always leaves a result in the response register.
   a_exec_result: assert property (@(posedge clock) disable iff (reset)
      ctrl.execute |=> rsp_valid_ff)
      else $error("executed operation produced no response");

   // Execution never overwrites a result that has not been taken.
   a_exec_room: assert property (@(posedge clock) disable iff (reset)
      ctrl.execute |-> (!rsp_valid_ff || rsp_ready))
      else $error("response overwritten before transfer");

   // The initialization sweep and operations never share the write port.
   a_sweep_excl: assert property (@(posedge clock) disable iff (reset)
      !(ctrl.sweep_en && (ctrl.execute || ctrl.capture)))
      else $error("operation during initialization sweep");

endmodule

// ===== src/fixed_block_free_list.sv =====
`timescale 1ns / 1ps
// Top level of the fixed-size block pool free list. The pool of NUM_BLOCKS blocks is kept as
// a LIFO linked list of free block indices in a link memory of NUM_BLOCKS entries. After
// reset an initialization sweep links every block of the link memory in ascending order,
// with req_ready low; then every block is free and block 0 is the head. A request is
// transferred in ST_IDLE, where the link memory is read at the head, and executed in
// ST_EXEC, which uses the registered read data to pop or writes the memory to push; ST_EXEC
// waits while the response register holds a result that is not taken. The next request is
// taken only after execution, but it is accepted while the previous response waits in the
// output register. Allocate returns the head block or ok low when the list is empty;
// free pushes the given block, or returns ok low when the pool is already full or the
// index is outside the pool. Each response carries the new free count in its low 9 bits.
module fixed_block_free_list
   import fbfl_pkg::*;
#(
   parameter int NUM_BLOCKS = 256
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [CMD_W-1:0]     req_command,
   input  logic [IDX_IN_W-1:0]  req_free_index,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_ok,
   output logic [BLK_OUT_W-1:0] rsp_block_index,
   output logic [CNT_OUT_W-1:0] rsp_free_count
);

   fbfl_ctrl_type ctrl;
   fbfl_stat_type stat;

   // Sequencing of sweep, request capture and execution.
   fbfl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .ctrl      (ctrl)
   );

   // Link memory, list state and response register.
   fbfl_dpath #(
      .NUM_BLOCKS (NUM_BLOCKS)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .ctrl            (ctrl),
      .stat            (stat),
      .req_command     (req_command),
      .req_free_index  (req_free_index),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_ok          (rsp_ok),
      .rsp_block_index (rsp_block_index),
      .rsp_free_count  (rsp_free_count)
   );

endmodule

// ===== tb/fixed_block_free_list_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the fixed-size block pool free list, with random handshake timing.
module fixed_block_free_list_test
   import fbfl_pkg::*;
();

   localparam int POOL_SIZE = 256;
   localparam logic [8:0] LINK_END = 9'(POOL_SIZE);
   localparam int RANDOM_ITEMS = 1730;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DIRECTED_ROWS = 20;

   // Kinds of random phase: mostly allocate, mostly free, or an even mix.
   localparam int PHASE_DRAIN = 0;
   localparam int PHASE_FILL  = 1;
   localparam int PHASE_MIX   = 2;

   typedef struct packed {
      logic                 ok;
      logic [BLK_OUT_W-1:0] block;
      logic [CNT_OUT_W-1:0] count;
   } pool_rsp_type;

   typedef struct packed {
      logic [CMD_W-1:0]    command;
      logic [IDX_IN_W-1:0] index;
      logic                typed;
      pool_rsp_type        answer;
   } stim_row_type;

   // Directed rows; typed answers hold only right after reset and at the full pool.
   localparam stim_row_type STIM_ROWS [0:DIRECTED_ROWS-1] = '{
      '{CMD_ALLOC, 8'h00, 1'b1, '{1'b1, 8'd0, 9'd255}},
      '{CMD_ALLOC, 8'hFF, 1'b1, '{1'b1, 8'd1, 9'd254}},
      '{CMD_FREE,  8'h00, 1'b1, '{1'b1, 8'd0, 9'd255}},
      '{CMD_ALLOC, 8'h00, 1'b1, '{1'b1, 8'd0, 9'd254}},
      '{CMD_FREE,  8'hFF, 1'b1, '{1'b1, 8'd0, 9'd255}},
      '{CMD_FREE,  8'h00, 1'b1, '{1'b1, 8'd0, 9'd256}},
      '{CMD_FREE,  8'h00, 1'b1, '{1'b0, 8'd0, 9'd256}},
      '{CMD_FREE,  8'hFF, 1'b1, '{1'b0, 8'd0, 9'd256}},
      '{CMD_ALLOC, 8'h00, 1'b0, '0},
      '{CMD_ALLOC, 8'hFF, 1'b0, '0},
      '{CMD_ALLOC, 8'h5A, 1'b0, '0},
      '{CMD_FREE,  8'hAA, 1'b0, '0},
      '{CMD_FREE,  8'h55, 1'b0, '0},
      '{CMD_ALLOC, 8'h00, 1'b0, '0},
      '{CMD_ALLOC, 8'hFF, 1'b0, '0},
      '{CMD_FREE,  8'h80, 1'b0, '0},
      '{CMD_FREE,  8'h01, 1'b0, '0},
      '{CMD_FREE,  8'h7F, 1'b0, '0},
      '{CMD_ALLOC, 8'hAA, 1'b0, '0},
      '{CMD_ALLOC, 8'h00, 1'b0, '0}
   };

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [CMD_W-1:0]     req_command = CMD_ALLOC;
   logic [IDX_IN_W-1:0]  req_free_index = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic                 rsp_ok;
   logic [BLK_OUT_W-1:0] rsp_block_index;
   logic [CNT_OUT_W-1:0] rsp_free_count;

   // Mirror of the pool state.
   logic [8:0] pool_link [POOL_SIZE];
   logic [8:0] pool_head;
   logic [8:0] pool_free;

   pool_rsp_type         expected_rsps [$];
   logic [IDX_IN_W-1:0]  held_blocks [$];
   int                   errors = 0;
   int                   cycle_count = 0;
   int                   send_calm = 0;
   int                   recv_calm = 0;

   fixed_block_free_list DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_command     (req_command),
      .req_free_index  (req_free_index),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_ok          (rsp_ok),
      .rsp_block_index (rsp_block_index),
      .rsp_free_count  (rsp_free_count)
   );

   // Clock generation.
   initial begin
      forever #5 clock = ~clock;
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Restore the pool to its reset state: all blocks linked in ascending order.
   task automatic clear_pool();
      for (int i = 0; i < POOL_SIZE; i++) begin
         pool_link[i] = 9'(i + 1);
      end
      pool_head = '0;
      pool_free = 9'(POOL_SIZE);
   endtask

   // Apply one command to the pool mirror and return the response it produces.
   function automatic pool_rsp_type apply_pool_op(input logic [CMD_W-1:0] command,
                                                 input logic [IDX_IN_W-1:0] index);
      pool_rsp_type result;
      result = '0;
      if (command == CMD_ALLOC) begin
         if (pool_head != LINK_END) begin
            result.ok = 1'b1;
            result.block = pool_head[7:0];
            pool_head = pool_link[pool_head[7:0]];
            if (pool_free != 0) begin
               pool_free = pool_free - 1'b1;
            end
         end
      end else if (pool_free < LINK_END) begin
         // Every 8-bit index lies inside the pool, so only a full pool rejects a free.
         pool_link[index] = pool_head;
         pool_head = {1'b0, index};
         pool_free = pool_free + 1'b1;
         result.ok = 1'b1;
      end
      result.count = pool_free;
      return result;
   endfunction

   // Wait length for one item; calm stretches hold the wait at zero for a while.
   function automatic int draw_wait(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 19) == 0) begin
         calm = $urandom_range(10, 40);
         return 0;
      end
      return $urandom_range(0, 17);
   endfunction

   // Present one request, wait for its transfer, and queue the expected response.
   task automatic send_request(input logic [CMD_W-1:0] command,
                               input logic [IDX_IN_W-1:0] index,
                               input logic typed, input pool_rsp_type answer);
      int           gap;
      pool_rsp_type predicted;
      gap = draw_wait(send_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= command;
      req_free_index <= index;
      do @(posedge clock); while (!req_ready);
      predicted = apply_pool_op(command, index);
      expected_rsps.push_back(typed ? answer : predicted);
      // Track which blocks the caller holds, so that most frees return one of them.
      if (predicted.ok && command == CMD_ALLOC) begin
         held_blocks.push_back(predicted.block);
      end else if (predicted.ok) begin
         for (int i = 0; i < held_blocks.size(); i++) begin
            if (held_blocks[i] == index) begin
               held_blocks.delete(i);
               break;
            end
         end
      end
   endtask

   // Response side: random stalls before each transfer.
   initial begin
      int stall;
      while (reset) @(posedge clock);
      forever begin
         stall = draw_wait(recv_calm);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // Compare each response transfer with the oldest expectation.
   always @(posedge clock) begin
      pool_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsps.size() == 0) begin
            $display("%0t: response with none expected: ok=%0d block=%0d count=%0d",
                     $time, rsp_ok, rsp_block_index, rsp_free_count);
            errors++;
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_ok !== want.ok) begin
               $display("%0t: ok expected %0d, got %0d", $time, want.ok, rsp_ok);
               errors++;
            end
            if (rsp_block_index !== want.block) begin
               $display("%0t: block_index expected %0d, got %0d",
                        $time, want.block, rsp_block_index);
               errors++;
            end
            if (rsp_free_count !== want.count) begin
               $display("%0t: free_count expected %0d, got %0d",
                        $time, want.count, rsp_free_count);
               errors++;
            end
         end
      end
   end

   // Stimulus: reset, directed rows, then random phases that drain and refill the pool.
   initial begin
      int                  sent;
      int                  kind;
      int                  span;
      int                  alloc_pct;
      logic [CMD_W-1:0]    command;
      logic [IDX_IN_W-1:0] index;
      clear_pool();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < DIRECTED_ROWS; r++) begin
         send_request(STIM_ROWS[r].command, STIM_ROWS[r].index,
                      STIM_ROWS[r].typed, STIM_ROWS[r].answer);
      end

      // The first two phases drain the pool with mostly allocates and refill it with mostly frees.
      sent = 0;
      kind = PHASE_DRAIN;
      span = 300;
      while (sent < RANDOM_ITEMS) begin
         alloc_pct = (kind == PHASE_DRAIN) ? 90 : (kind == PHASE_FILL) ? 10 : 50;
         for (int n = 0; n < span && sent < RANDOM_ITEMS; n++) begin
            command = ($urandom_range(0, 99) < alloc_pct) ? CMD_ALLOC : CMD_FREE;
            index = 8'($urandom_range(0, 255));
            // Most frees return a held block; the rest are double frees or rejects.
            if (command == CMD_FREE && held_blocks.size() > 0 && $urandom_range(0, 99) < 85) begin
               index = held_blocks[$urandom_range(0, held_blocks.size() - 1)];
            end
            send_request(command, index, 1'b0, '0);
            sent++;
         end
         if (kind == PHASE_DRAIN && span == 300) begin
            kind = PHASE_FILL;
            span = 320;
         end else begin
            kind = $urandom_range(PHASE_DRAIN, PHASE_MIX);
            span = $urandom_range(40, 250);
         end
      end
      req_valid <= 1'b0;

      // Drain outstanding responses, then watch for stray ones.
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
